[rtl/core/ocap_pkg.sv]
`default_nettype none
package ocap_pkg;

   localparam int COORD_WIDTH_DEF    = 32;
   localparam int TRIG_FRAC_BITS_DEF = 16;
   localparam int ANGLE_WIDTH        = 17;
   localparam int R_WIDTH            = 14;

   localparam int DEG_UNITS    = 256;
   localparam int HALF_TURN    = 180 * DEG_UNITS;
   localparam int FULL_TURN    = 2 * HALF_TURN;
   localparam int QUARTER_TURN = HALF_TURN / 2;
   localparam int EIGHTH_TURN  = HALF_TURN / 4;
   localparam logic [18:0] RAD_PER_UNIT = 19'd292818;

   localparam int TRIG_LAT = 11;
   localparam int ROT_LAT  = 2;

   localparam int DIV6_SHIFT      = 35;
   localparam int DIV24_SHIFT     = 37;
   localparam int DIV120_SHIFT    = 39;
   localparam int DIV720_SHIFT    = 42;
   localparam int DIV5040_SHIFT   = 45;
   localparam int DIV40320_SHIFT  = 48;
   localparam int DIV362880_SHIFT = 51;

   localparam logic [32:0] DIV6_MULT =
      33'(((64'd1 << DIV6_SHIFT) + 64'd5) / 64'd6);
   localparam logic [32:0] DIV24_MULT =
      33'(((64'd1 << DIV24_SHIFT) + 64'd23) / 64'd24);
   localparam logic [32:0] DIV120_MULT =
      33'(((64'd1 << DIV120_SHIFT) + 64'd119) / 64'd120);
   localparam logic [32:0] DIV720_MULT =
      33'(((64'd1 << DIV720_SHIFT) + 64'd719) / 64'd720);
   localparam logic [32:0] DIV5040_MULT =
      33'(((64'd1 << DIV5040_SHIFT) + 64'd5039) / 64'd5040);
   localparam logic [32:0] DIV40320_MULT =
      33'(((64'd1 << DIV40320_SHIFT) + 64'd40319) / 64'd40320);
   localparam logic [32:0] DIV362880_MULT =
      33'(((64'd1 << DIV362880_SHIFT) + 64'd362879) / 64'd362880);

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   function automatic logic [31:0] div_by(input logic [31:0] x, input logic [32:0] m,
                                          input int sh);
      logic [64:0] p;
      p = 65'(x) * 65'(m);
      return 32'(p >> sh);
   endfunction

   function automatic logic [31:0] mul_hi(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      p = 64'(a) * 64'(b);
      return p[63:32];
   endfunction

endpackage
`default_nettype wire

[rtl/core/ocap_trig.sv]
`default_nettype none
module ocap_trig #(
   parameter int TRIG_FRAC_BITS = ocap_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  en,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0]      angle,
   output logic signed [TRIG_FRAC_BITS+1:0]           sin_out,
   output logic signed [TRIG_FRAC_BITS+1:0]           cos_out
);
   import ocap_pkg::*;

   localparam int F  = TRIG_FRAC_BITS;
   localparam int RS = 32 - F;

   logic [ANGLE_WIDTH-1:0] a_ff, a_in;
   logic [R_WIDTH-1:0]     r_ff, r_in;
   quad_type               quad_ff [2:10];
   quad_type               quad_in;
   logic                   swap_ff [2:9];
   logic                   swap_in;
   logic [ANGLE_WIDTH-1:0] rq;

   logic [31:0] t_c_ff;
   logic [31:0] t_d_ff, t2_d_ff;
   logic [31:0] t_e_ff, t2_e_ff, t3_e_ff, t4_e_ff;
   logic [31:0] t_f_ff, t2_f_ff, t5_f_ff, t6_f_ff, d2_f_ff, d3_f_ff, d4_f_ff;
   logic [31:0] t_g_ff, t2_g_ff, t7_g_ff, t8_g_ff, d2_g_ff, d3_g_ff, d4_g_ff;
   logic [31:0] d5_g_ff, d6_g_ff;
   logic [31:0] t_h_ff, t9_h_ff, d2_h_ff, d3_h_ff, d4_h_ff, d5_h_ff, d6_h_ff;
   logic [31:0] d7_h_ff, d8_h_ff;
   logic [31:0] d9_i_ff;
   logic [34:0] sp_i_ff, cv_i_ff;
   logic [34:0] sv_full, sr_full, cr_full;
   logic [F:0]  so_j_ff, co_j_ff, so_in, co_in;
   logic signed [F+1:0] sin_ff, cos_ff, sin_in, cos_in;
   logic [32:0] t_prod;

   always_comb begin
      a_in = (angle >= ANGLE_WIDTH'(FULL_TURN)) ? angle - ANGLE_WIDTH'(FULL_TURN) : angle;
   end

   always_comb begin
      priority if (a_ff < ANGLE_WIDTH'(QUARTER_TURN)) begin
         quad_in = QUAD_0;
         rq      = a_ff;
      end else if (a_ff < ANGLE_WIDTH'(2 * QUARTER_TURN)) begin
         quad_in = QUAD_1;
         rq      = a_ff - ANGLE_WIDTH'(QUARTER_TURN);
      end else if (a_ff < ANGLE_WIDTH'(3 * QUARTER_TURN)) begin
         quad_in = QUAD_2;
         rq      = a_ff - ANGLE_WIDTH'(2 * QUARTER_TURN);
      end else begin
         quad_in = QUAD_3;
         rq      = a_ff - ANGLE_WIDTH'(3 * QUARTER_TURN);
      end
      swap_in = rq > ANGLE_WIDTH'(EIGHTH_TURN);
      r_in    = swap_in ? R_WIDTH'(ANGLE_WIDTH'(QUARTER_TURN) - rq) : R_WIDTH'(rq);
   end

   assign t_prod = 33'(r_ff) * 33'(RAD_PER_UNIT);

   always_comb begin
      sv_full = sp_i_ff + 35'(d9_i_ff);
      sr_full = (sv_full + (35'(1) << (RS - 1))) >> RS;
      cr_full = (cv_i_ff + (35'(1) << (RS - 1))) >> RS;
      so_in   = swap_ff[9] ? cr_full[F:0] : sr_full[F:0];
      co_in   = swap_ff[9] ? sr_full[F:0] : cr_full[F:0];
   end

   always_comb begin
      unique case (quad_ff[10])
         QUAD_0: begin
            sin_in = $signed({1'b0, so_j_ff});
            cos_in = $signed({1'b0, co_j_ff});
         end
         QUAD_1: begin
            sin_in = $signed({1'b0, co_j_ff});
            cos_in = -$signed({1'b0, so_j_ff});
         end
         QUAD_2: begin
            sin_in = -$signed({1'b0, so_j_ff});
            cos_in = -$signed({1'b0, co_j_ff});
         end
         QUAD_3: begin
            sin_in = -$signed({1'b0, co_j_ff});
            cos_in = $signed({1'b0, so_j_ff});
         end
         default: begin
            sin_in = '0;
            cos_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff       <= a_in;
         r_ff       <= r_in;
         quad_ff[2] <= quad_in;
         swap_ff[2] <= swap_in;
         for (int i = 3; i <= 10; i++) begin
            quad_ff[i] <= quad_ff[i-1];
         end
         for (int i = 3; i <= 9; i++) begin
            swap_ff[i] <= swap_ff[i-1];
         end

         t_c_ff  <= t_prod[31:0];

         t_d_ff  <= t_c_ff;
         t2_d_ff <= mul_hi(t_c_ff, t_c_ff);

         t_e_ff  <= t_d_ff;
         t2_e_ff <= t2_d_ff;
         t3_e_ff <= mul_hi(t2_d_ff, t_d_ff);
         t4_e_ff <= mul_hi(t2_d_ff, t2_d_ff);

         t_f_ff  <= t_e_ff;
         t2_f_ff <= t2_e_ff;
         t5_f_ff <= mul_hi(t3_e_ff, t2_e_ff);
         t6_f_ff <= mul_hi(t4_e_ff, t2_e_ff);
         d2_f_ff <= t2_e_ff >> 1;
         d3_f_ff <= div_by(t3_e_ff, DIV6_MULT, DIV6_SHIFT);
         d4_f_ff <= div_by(t4_e_ff, DIV24_MULT, DIV24_SHIFT);

         t_g_ff  <= t_f_ff;
         t2_g_ff <= t2_f_ff;
         t7_g_ff <= mul_hi(t5_f_ff, t2_f_ff);
         t8_g_ff <= mul_hi(t6_f_ff, t2_f_ff);
         d2_g_ff <= d2_f_ff;
         d3_g_ff <= d3_f_ff;
         d4_g_ff <= d4_f_ff;
         d5_g_ff <= div_by(t5_f_ff, DIV120_MULT, DIV120_SHIFT);
         d6_g_ff <= div_by(t6_f_ff, DIV720_MULT, DIV720_SHIFT);

         t_h_ff  <= t_g_ff;
         t9_h_ff <= mul_hi(t7_g_ff, t2_g_ff);
         d2_h_ff <= d2_g_ff;
         d3_h_ff <= d3_g_ff;
         d4_h_ff <= d4_g_ff;
         d5_h_ff <= d5_g_ff;
         d6_h_ff <= d6_g_ff;
         d7_h_ff <= div_by(t7_g_ff, DIV5040_MULT, DIV5040_SHIFT);
         d8_h_ff <= div_by(t8_g_ff, DIV40320_MULT, DIV40320_SHIFT);

         d9_i_ff <= div_by(t9_h_ff, DIV362880_MULT, DIV362880_SHIFT);
         sp_i_ff <= 35'(t_h_ff) + 35'(d5_h_ff) - 35'(d3_h_ff) - 35'(d7_h_ff);
         cv_i_ff <= (35'(1) << 32) + 35'(d4_h_ff) + 35'(d8_h_ff)
                    - 35'(d2_h_ff) - 35'(d6_h_ff);

         so_j_ff <= so_in;
         co_j_ff <= co_in;

         sin_ff  <= sin_in;
         cos_ff  <= cos_in;
      end
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
`default_nettype wire

[rtl/core/ocap_rot.sv]
`default_nettype none
module ocap_rot #(
   parameter int COORD_WIDTH    = ocap_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = ocap_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                en,
   input  wire logic signed [COORD_WIDTH:0]         u,
   input  wire logic signed [COORD_WIDTH:0]         v,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]    c,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]    s,
   output logic signed [COORD_WIDTH:0]              out_a,
   output logic signed [COORD_WIDTH:0]              out_b
);
   import ocap_pkg::*;

   localparam int CW = COORD_WIDTH;
   localparam int F  = TRIG_FRAC_BITS;
   localparam int PW = CW + F + 3;

   logic signed [PW-1:0] uc_ff, vs_ff, vc_ff, us_ff;
   logic signed [PW:0]   sum_a, sum_b, half;
   logic signed [CW:0]   a_in, b_in, a_ff, b_ff;

   function automatic logic signed [CW:0] sat(input logic signed [PW:0] x);
      logic [3:0] hi;
      hi = x[PW:PW-3];
      if ((&hi) || !(|hi)) begin
         return x[CW+F:F];
      end
      return {x[PW], {CW{~x[PW]}}};
   endfunction

   always_comb begin
      half  = (PW+1)'(1) <<< (F - 1);
      sum_a = (PW+1)'(uc_ff) + (PW+1)'(vs_ff) + half;
      sum_b = (PW+1)'(vc_ff) - (PW+1)'(us_ff) + half;
      a_in  = sat(sum_a);
      b_in  = sat(sum_b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         uc_ff <= PW'(u * c);
         vs_ff <= PW'(v * s);
         vc_ff <= PW'(v * c);
         us_ff <= PW'(u * s);
         a_ff  <= a_in;
         b_ff  <= b_in;
      end
   end

   assign out_a = a_ff;
   assign out_b = b_ff;

endmodule
`default_nettype wire

[rtl/core/octahedron_capture_test_core.sv]
// Throughput: one beat per cycle while rsp_stall is not holding a response;
// the trig pipelines and three rotation stages are fully pipelined, and a
// response stall freezes the whole pipe.
// Reset clears the pipeline valid bits only; data registers are not reset.
`default_nettype none
module octahedron_capture_test_core #(
   parameter int COORD_WIDTH    = ocap_pkg::COORD_WIDTH_DEF,
   parameter int TRIG_FRAC_BITS = ocap_pkg::TRIG_FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0]  req_angle_first,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0]  req_angle_middle,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0]  req_angle_last,
   input  wire logic signed [COORD_WIDTH-1:0]     req_center_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_center_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_center_z,
   input  wire logic [COORD_WIDTH-2:0]            req_half_diagonal,
   input  wire logic signed [COORD_WIDTH-1:0]     req_cell_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_cell_y,
   input  wire logic signed [COORD_WIDTH-1:0]     req_cell_z,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_captured
);
   import ocap_pkg::*;

   localparam int CW   = COORD_WIDTH;
   localparam int F    = TRIG_FRAC_BITS;
   localparam int R1   = TRIG_LAT;
   localparam int R2   = R1 + ROT_LAT;
   localparam int R3   = R2 + ROT_LAT;
   localparam int R4   = R3 + ROT_LAT;
   localparam int SABS = R4 + 1;
   localparam int SSUM = SABS + 1;
   localparam int LAT  = SSUM + 1;

   logic                en;
   logic [LAT:1]        valid_ff;

   logic signed [CW:0]  off_x_ff [1:R1];
   logic signed [CW:0]  off_y_ff [1:R1];
   logic signed [CW:0]  off_z_ff [1:R2];
   logic [CW-2:0]       rad_ff [1:SSUM];

   logic signed [F+1:0] sin1, cos1, sin2, cos2, sin3, cos3;
   logic signed [F+1:0] sin2_ff [R1+1:R2];
   logic signed [F+1:0] cos2_ff [R1+1:R2];
   logic signed [F+1:0] sin3_ff [R1+1:R3];
   logic signed [F+1:0] cos3_ff [R1+1:R3];

   logic signed [CW:0]  x1, y1, y2, z2, x3, y3;
   logic signed [CW:0]  x1_ff [R2+1:R3];
   logic signed [CW:0]  z2_ff [R3+1:R4];

   logic [CW:0]         ax_ff, ay_ff, az_ff;
   logic [CW+2:0]       norm_ff;
   logic                captured_ff;

   assign en        = !(valid_ff[LAT] && rsp_stall);
   assign req_stall = !en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-1:1], req_valid};
      end
   end

   ocap_trig #(.TRIG_FRAC_BITS(F)) u_trig_first (
      .clock(clock), .en(en), .angle(req_angle_first), .sin_out(sin1), .cos_out(cos1)
   );
   ocap_trig #(.TRIG_FRAC_BITS(F)) u_trig_middle (
      .clock(clock), .en(en), .angle(req_angle_middle), .sin_out(sin2), .cos_out(cos2)
   );
   ocap_trig #(.TRIG_FRAC_BITS(F)) u_trig_last (
      .clock(clock), .en(en), .angle(req_angle_last), .sin_out(sin3), .cos_out(cos3)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         off_x_ff[1] <= $signed({req_cell_x[CW-1], req_cell_x})
                        - $signed({req_center_x[CW-1], req_center_x});
         off_y_ff[1] <= $signed({req_cell_y[CW-1], req_cell_y})
                        - $signed({req_center_y[CW-1], req_center_y});
         off_z_ff[1] <= $signed({req_cell_z[CW-1], req_cell_z})
                        - $signed({req_center_z[CW-1], req_center_z});
         rad_ff[1]   <= req_half_diagonal;
         for (int i = 2; i <= R1; i++) begin
            off_x_ff[i] <= off_x_ff[i-1];
            off_y_ff[i] <= off_y_ff[i-1];
         end
         for (int i = 2; i <= R2; i++) begin
            off_z_ff[i] <= off_z_ff[i-1];
         end
         for (int i = 2; i <= SSUM; i++) begin
            rad_ff[i] <= rad_ff[i-1];
         end
         sin2_ff[R1+1] <= sin2;
         cos2_ff[R1+1] <= cos2;
         sin3_ff[R1+1] <= sin3;
         cos3_ff[R1+1] <= cos3;
         for (int i = R1 + 2; i <= R2; i++) begin
            sin2_ff[i] <= sin2_ff[i-1];
            cos2_ff[i] <= cos2_ff[i-1];
         end
         for (int i = R1 + 2; i <= R3; i++) begin
            sin3_ff[i] <= sin3_ff[i-1];
            cos3_ff[i] <= cos3_ff[i-1];
         end
         x1_ff[R2+1] <= x1;
         for (int i = R2 + 2; i <= R3; i++) begin
            x1_ff[i] <= x1_ff[i-1];
         end
         z2_ff[R3+1] <= z2;
         for (int i = R3 + 2; i <= R4; i++) begin
            z2_ff[i] <= z2_ff[i-1];
         end
         ax_ff       <= x3[CW] ? (CW+1)'(-x3) : (CW+1)'(x3);
         ay_ff       <= y3[CW] ? (CW+1)'(-y3) : (CW+1)'(y3);
         az_ff       <= z2_ff[R4][CW] ? (CW+1)'(-z2_ff[R4]) : (CW+1)'(z2_ff[R4]);
         norm_ff     <= (CW+3)'(ax_ff) + (CW+3)'(ay_ff) + (CW+3)'(az_ff);
         captured_ff <= norm_ff < (CW+3)'(rad_ff[SSUM]);
      end
   end

   ocap_rot #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(F)) u_rot_first (
      .clock(clock), .en(en), .u(off_x_ff[R1]), .v(off_y_ff[R1]),
      .c(cos1), .s(sin1), .out_a(x1), .out_b(y1)
   );
   ocap_rot #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(F)) u_rot_middle (
      .clock(clock), .en(en), .u(y1), .v(off_z_ff[R2]),
      .c(cos2_ff[R2]), .s(sin2_ff[R2]), .out_a(y2), .out_b(z2)
   );
   ocap_rot #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(F)) u_rot_last (
      .clock(clock), .en(en), .u(x1_ff[R3]), .v(y2),
      .c(cos3_ff[R3]), .s(sin3_ff[R3]), .out_a(x3), .out_b(y3)
   );

   assign rsp_valid    = valid_ff[LAT];
   assign rsp_captured = captured_ff;

`ifndef SYNTHESIS
   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(valid_ff))
      else $error("pipeline moved while response stalled");
   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[1])
      else $error("accepted beat lost at pipeline entry");
   a_reset_clears_pipe: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("valid bits not cleared by reset");
`endif

endmodule
`default_nettype wire

[bench/octahedron_capture_checker.sv]
module octahedron_capture_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0] req_angle_first,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0] req_angle_middle,
   input  wire logic [ocap_pkg::ANGLE_WIDTH-1:0] req_angle_last,
   input  wire logic signed [31:0]               req_center_x,
   input  wire logic signed [31:0]               req_center_y,
   input  wire logic signed [31:0]               req_center_z,
   input  wire logic [30:0]                      req_half_diagonal,
   input  wire logic signed [31:0]               req_cell_x,
   input  wire logic signed [31:0]               req_cell_y,
   input  wire logic signed [31:0]               req_cell_z,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic                             rsp_captured,
   output int                                    mismatches,
   output int                                    outstanding
);
   import ocap_pkg::*;

   localparam int FRAC = TRIG_FRAC_BITS_DEF;
   localparam longint SAT_HI = (64'sd1 <<< COORD_WIDTH_DEF) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< COORD_WIDTH_DEF);

   bit capture_queue[$];

   function automatic longint round_frac(logic [63:0] v);
      return longint'((v + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
   endfunction

   function automatic void octant_trig(input int unsigned r, output longint s,
                                       output longint c);
      logic [63:0] t, t2, t3, t4, t5, t6, t7, t8, t9, sv, cv;
      t  = 64'(r) * 64'(RAD_PER_UNIT);
      t2 = (t * t) >> 32;
      t3 = (t2 * t) >> 32;
      t5 = (t3 * t2) >> 32;
      t7 = (t5 * t2) >> 32;
      t9 = (t7 * t2) >> 32;
      t4 = (t2 * t2) >> 32;
      t6 = (t4 * t2) >> 32;
      t8 = (t6 * t2) >> 32;
      sv = (t + t5 / 120 + t9 / 362880) - (t3 / 6 + t7 / 5040);
      cv = ((64'd1 << 32) + t4 / 24 + t8 / 40320) - (t2 / 2 + t6 / 720);
      s = round_frac(sv);
      c = round_frac(cv);
   endfunction

   function automatic void angle_trig(input logic [ANGLE_WIDTH-1:0] angle,
                                      output longint s, output longint c);
      int unsigned a, r;
      longint so, co;
      quad_type q;
      a = angle;
      if (a >= FULL_TURN) a -= FULL_TURN;
      q = quad_type'(a / QUARTER_TURN);
      r = a - (a / QUARTER_TURN) * QUARTER_TURN;
      if (r <= EIGHTH_TURN) octant_trig(r, so, co);
      else octant_trig(QUARTER_TURN - r, co, so);
      case (q)
         QUAD_0: begin s = so;  c = co;  end
         QUAD_1: begin s = co;  c = -so; end
         QUAD_2: begin s = -so; c = -co; end
         default: begin s = -co; c = so; end
      endcase
   endfunction

   function automatic longint rotate_term(longint u, longint p, longint v, longint q);
      longint acc;
      acc = (u * p + v * q + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      if (acc > SAT_HI) return SAT_HI;
      if (acc < SAT_LO) return SAT_LO;
      return acc;
   endfunction

   function automatic longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit predict_capture();
      longint s, c, x, y, z, x1, y1, y2, z2, x3, y3, norm;
      x = longint'(req_cell_x) - longint'(req_center_x);
      y = longint'(req_cell_y) - longint'(req_center_y);
      z = longint'(req_cell_z) - longint'(req_center_z);
      angle_trig(req_angle_first, s, c);
      x1 = rotate_term(x, c, y, s);
      y1 = rotate_term(y, c, x, -s);
      angle_trig(req_angle_middle, s, c);
      y2 = rotate_term(y1, c, z, s);
      z2 = rotate_term(z, c, y1, -s);
      angle_trig(req_angle_last, s, c);
      x3 = rotate_term(x1, c, y2, s);
      y3 = rotate_term(y2, c, x1, -s);
      norm = magnitude(x3) + magnitude(y3) + magnitude(z2);
      return norm < longint'(req_half_diagonal);
   endfunction

   always @(posedge clock) begin
      bit want;
      if (reset) begin
         mismatches = 0;
      end else begin
         if (req_valid && !req_stall) capture_queue.push_back(predict_capture());
         if (rsp_valid && !rsp_stall) begin
            if (capture_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat, captured=%0d", rsp_captured);
            end else begin
               want = capture_queue.pop_front();
               if (rsp_captured !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("captured mismatch: expected %0d actual %0d", want, rsp_captured);
               end
            end
         end
      end
      outstanding = capture_queue.size();
   end
endmodule

[bench/tb_octahedron_capture_test_core.sv]
module tb_octahedron_capture_test_core;
   import ocap_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [ANGLE_WIDTH-1:0] req_angle_first = 0, req_angle_middle = 0, req_angle_last = 0;
   logic signed [31:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic [30:0] req_half_diagonal = 0;
   logic signed [31:0] req_cell_x = 0, req_cell_y = 0, req_cell_z = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_captured;
   int mismatches, outstanding;
   int cycle_count = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   octahedron_capture_test_core dut (.*);

   octahedron_capture_checker checker_i (.*);

   function automatic bit quiet_window();
      return cycle_count > 400 && cycle_count < 800;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall <= quiet_window() ? 1'b0 : ($urandom_range(0, 99) < 10);
      if (cycle_count > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(input logic [16:0] a1, a2, a3,
                            input logic [31:0] cx, cy, cz,
                            input logic [30:0] hd,
                            input logic [31:0] px, py, pz);
      req_angle_first <= a1; req_angle_middle <= a2; req_angle_last <= a3;
      req_center_x <= cx; req_center_y <= cy; req_center_z <= cz;
      req_half_diagonal <= hd;
      req_cell_x <= px; req_cell_y <= py; req_cell_z <= pz;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (!quiet_window() && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] near_offset(int k);
      return 32'($signed($urandom_range(0, (1 << k) - 1)) - (1 << (k - 1)));
   endfunction

   initial begin
      int k;
      logic [31:0] cx, cy, cz;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // extremes, wrap of angles, saturation, zero radius
      send_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_beat(0, 0, 0, 0, 0, 0, 31'h7fffffff, 0, 0, 0);
      send_beat(92159, 92159, 92159, 0, 0, 0, 31'h100, 32'h40, 32'h40, 32'h40);
      send_beat(92160, 100000, 131071, 0, 0, 0, 31'h10000, 32'h100, 0, 0);
      send_beat(131071, 131071, 131071, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                31'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000);
      send_beat(11520, 11520, 11520, 32'h80000000, 32'h80000000, 32'h80000000,
                31'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_beat(11520, 34560, 57600, 32'h80000000, 32'h7fffffff, 32'h80000000,
                31'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_beat(23040, 46080, 69120, 0, 0, 0, 31'h10000, 32'h8000, 32'h8000, 0);
      send_beat(11521, 11519, 23039, 32'h12345678, 0, 0, 0, 32'h12345678, 0, 0);
      send_beat(0, 0, 0, 0, 0, 0, 31'h10000, 32'h10000, 0, 0);
      send_beat(0, 0, 0, 0, 0, 0, 31'h10001, 32'h10000, 0, 0);
      send_beat(0, 0, 0, 0, 0, 0, 31'h10000, 32'hffff0001, 0, 0);
      send_beat(17, 92000, 5000, 32'h7fffffff, 32'h80000000, 0,
                31'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
      repeat (800) begin
         if ($urandom_range(0, 99) < 70) begin
            k = $urandom_range(4, 29);
            cx = 32'($signed($urandom()) >>> 2);
            cy = 32'($signed($urandom()) >>> 2);
            cz = 32'($signed($urandom()) >>> 2);
            send_beat(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                      17'($urandom_range(0, 131071)), cx, cy, cz,
                      31'($urandom_range(0, (1 << k) + (1 << (k - 1)))),
                      cx + near_offset(k), cy + near_offset(k), cz + near_offset(k));
         end else begin
            send_beat(17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                      17'($urandom_range(0, 131071)), $urandom(), $urandom(), $urandom(),
                      31'($urandom()), $urandom(), $urandom(), $urandom());
         end
      end
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
